// ===== rtl/core/assert_macros.svh =====
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("implication check failed");

// Next-cycle implication, held off while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("next-cycle check failed");

`endif

// ===== rtl/core/hdhk_pkg.sv =====
`default_nettype none

package hdhk_pkg;

    // Width of the delay and debounce registers and their countdowns
    localparam int CNT_W = 16;
    localparam int IDX_W = 3;

    typedef logic [CNT_W-1:0] cnt_t;

    // Configuration register indexes
    typedef enum logic [IDX_W-1:0] {
        REG_DETECT_ACTIVE_LOW     = 3'd0,
        REG_BUTTON_ACTIVE_LOW     = 3'd1,
        REG_DETECT_DEBOUNCE_TICKS = 3'd2,
        REG_BUTTON_DEBOUNCE_TICKS = 3'd3,
        REG_VALID_DELAY_TICKS     = 3'd4,
        REG_LONG_PRESS_TICKS      = 3'd5
    } reg_idx_t;

    // Reset values of the configuration registers
    localparam cnt_t DETECT_DEBOUNCE_RST = 16'd1;
    localparam cnt_t BUTTON_DEBOUNCE_RST = 16'd10;
    localparam cnt_t VALID_DELAY_RST     = 16'd50;
    localparam cnt_t LONG_PRESS_RST      = 16'd150;

    // A programmed delay of zero loads as one tick
    function automatic cnt_t load_of(input cnt_t v);
        cnt_t r;
        r = (v == '0) ? cnt_t'(1) : v;
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/headset_detect_hook_key.sv =====
`default_nettype none
`include "assert_macros.svh"

// Headset jack detect and hook key debounce. Each input beat is one timer
// tick carrying the raw detect and button levels and a resume flag; each
// tick gives exactly one result beat with debounced presence, a presence
// change strobe, short and long press strobes and the button enable. The
// whole state update is one pass of logic from the state registers into the
// state and result registers, so a tick can be accepted every cycle while
// the output register is empty or being taken; results are registered. The
// user writes configuration via the cfg port (index per register list,
// always ready) only while no tick is pending; the block does not enforce it.
module headset_detect_hook_key #(
    parameter int TICK_BITS = 16
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    // configuration write channel
    input  wire logic                       cfg_valid,
    output      logic                       cfg_ready,
    input  wire logic [hdhk_pkg::IDX_W-1:0] cfg_index,
    input  wire logic [hdhk_pkg::CNT_W-1:0] cfg_data,
    // tick input channel
    input  wire logic                       in_valid,
    output      logic                       in_ready,
    input  wire logic                       detect_level,
    input  wire logic                       button_level,
    input  wire logic                       resume_event,
    // result channel
    output      logic                       out_valid,
    input  wire logic                       out_ready,
    output      logic                       headset_present,
    output      logic                       presence_changed,
    output      logic                       short_press,
    output      logic                       long_press,
    output      logic                       button_enabled
);
    import hdhk_pkg::*;

    localparam int CMP_W = (TICK_BITS > CNT_W) ? TICK_BITS : CNT_W;
    localparam logic [TICK_BITS-1:0] PE_MAX = {TICK_BITS{1'b1}};

    // configuration registers
    logic det_al_reg;
    logic btn_al_reg;
    cnt_t det_deb_reg;
    cnt_t btn_deb_reg;
    cnt_t valid_delay_reg;
    cnt_t long_ticks_reg;

    // tick state
    logic                 present_reg, present_next;
    logic                 pressed_reg, pressed_next;
    logic                 honoured_reg, honoured_next;
    cnt_t                 valid_cnt_reg, valid_cnt_next;
    cnt_t                 det_cnt_reg, det_cnt_next;
    cnt_t                 btn_cnt_reg, btn_cnt_next;
    logic [TICK_BITS-1:0] elapsed_reg, elapsed_next;
    logic                 suppress_reg, suppress_next;

    // result register
    logic out_valid_reg;
    logic present_out_reg;
    logic changed_reg, changed_next;
    logic short_reg, short_next;
    logic long_reg, long_next;

    logic det;
    logic btn;
    logic accept;

    assign cfg_ready = 1'b1;
    assign in_ready  = !out_valid_reg || out_ready;
    assign accept    = in_valid && in_ready;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            det_al_reg      <= 1'b0;
            btn_al_reg      <= 1'b0;
            det_deb_reg     <= DETECT_DEBOUNCE_RST;
            btn_deb_reg     <= BUTTON_DEBOUNCE_RST;
            valid_delay_reg <= VALID_DELAY_RST;
            long_ticks_reg  <= LONG_PRESS_RST;
        end
        else if (cfg_valid)
        begin
            unique case (reg_idx_t'(cfg_index))
                REG_DETECT_ACTIVE_LOW:     det_al_reg      <= cfg_data[0];
                REG_BUTTON_ACTIVE_LOW:     btn_al_reg      <= cfg_data[0];
                REG_DETECT_DEBOUNCE_TICKS: det_deb_reg     <= cfg_data;
                REG_BUTTON_DEBOUNCE_TICKS: btn_deb_reg     <= cfg_data;
                REG_VALID_DELAY_TICKS:     valid_delay_reg <= cfg_data;
                REG_LONG_PRESS_TICKS:      long_ticks_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // Bring raw levels to active polarity
    assign det = detect_level ^ det_al_reg;
    assign btn = button_level ^ btn_al_reg;

    // One tick of the detect and button state update
    always_comb
    begin
        present_next  = present_reg;
        pressed_next  = pressed_reg;
        honoured_next = honoured_reg;
        valid_cnt_next = valid_cnt_reg;
        det_cnt_next  = det_cnt_reg;
        btn_cnt_next  = btn_cnt_reg;
        elapsed_next  = elapsed_reg;
        suppress_next = suppress_reg || resume_event;
        changed_next  = 1'b0;
        short_next    = 1'b0;
        long_next     = 1'b0;

        // advance the hold timer, saturating
        if (pressed_reg && (elapsed_reg != PE_MAX))
            elapsed_next = elapsed_reg + TICK_BITS'(1);

        // run the validity delay after insertion
        if (valid_cnt_reg != '0)
        begin
            valid_cnt_next = valid_cnt_reg - cnt_t'(1);
            if (valid_cnt_reg == cnt_t'(1))
                honoured_next = 1'b1;
        end

        // run the detect debounce and confirm on expiry
        if (det_cnt_reg != '0)
        begin
            det_cnt_next = det_cnt_reg - cnt_t'(1);
            if ((det_cnt_reg == cnt_t'(1)) && (det != present_reg))
            begin
                present_next   = det;
                changed_next   = 1'b1;
                honoured_next  = 1'b0;
                valid_cnt_next = det ? load_of(valid_delay_reg) : '0;
                pressed_next   = 1'b0;
            end
        end

        // run the button debounce and sample on expiry
        if (btn_cnt_reg != '0)
        begin
            btn_cnt_next = btn_cnt_reg - cnt_t'(1);
            if (btn_cnt_reg == cnt_t'(1))
            begin
                if (!det || !honoured_next)
                    pressed_next = 1'b0;
                else if (btn != pressed_next)
                begin
                    if (btn)
                        elapsed_next = '0;
                    else if (CMP_W'(elapsed_next) > CMP_W'(long_ticks_reg))
                        long_next = 1'b1;
                    else if (suppress_next)
                        suppress_next = 1'b0;
                    else
                        short_next = 1'b1;
                    pressed_next = btn;
                end
            end
        end

        // start new debounce counts when idle
        if ((det_cnt_next == '0) && (det != present_next))
            det_cnt_next = load_of(det_deb_reg);

        if ((btn_cnt_next == '0) && present_next && honoured_next &&
            (btn != pressed_next))
            btn_cnt_next = load_of(btn_deb_reg);
    end

    // Hold state, advance on each accepted tick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            present_reg   <= 1'b0;
            pressed_reg   <= 1'b0;
            honoured_reg  <= 1'b0;
            valid_cnt_reg <= '0;
            det_cnt_reg   <= '0;
            btn_cnt_reg   <= '0;
            elapsed_reg   <= '0;
            suppress_reg  <= 1'b0;
        end
        else if (accept)
        begin
            present_reg   <= present_next;
            pressed_reg   <= pressed_next;
            honoured_reg  <= honoured_next;
            valid_cnt_reg <= valid_cnt_next;
            det_cnt_reg   <= det_cnt_next;
            btn_cnt_reg   <= btn_cnt_next;
            elapsed_reg   <= elapsed_next;
            suppress_reg  <= suppress_next;
        end
    end

    // Output beat valid: set on accept, drop when taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (accept)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    // Output beat payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            present_out_reg <= present_next;
            changed_reg     <= changed_next;
            short_reg       <= short_next;
            long_reg        <= long_next;
        end
    end

    assign out_valid        = out_valid_reg;
    assign headset_present  = present_out_reg;
    assign presence_changed = changed_reg;
    assign short_press      = short_reg;
    assign long_press       = long_reg;
    assign button_enabled   = present_out_reg;

    // Button honoured only with a headset present
    `ASSERT_IMPLIES(a_honoured_present, clk, rst_n, honoured_reg, present_reg)
    // Pressed state only while the button is honoured
    `ASSERT_IMPLIES(a_pressed_honoured, clk, rst_n, pressed_reg, honoured_reg)
    // Validity delay runs only after insertion, before honouring
    `ASSERT_IMPLIES(a_valid_delay, clk, rst_n, valid_cnt_reg != '0,
                    present_reg && !honoured_reg)
    // Never report both press kinds on one tick
    `ASSERT_IMPLIES(a_one_press, clk, rst_n, out_valid_reg, !(short_reg && long_reg))
    // An accepted tick always leaves a result beat
    `ASSERT_NEXT(a_accept_result, clk, rst_n, accept, out_valid_reg)

endmodule

`default_nettype wire
